// ===== rtl/mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and constants of the metaball field shader.
// ----------------------------------------------------------------------------
package mfs_pkg;

	localparam int QW = 24;
	localparam logic [QW-1:0] Q_MAX = {QW{1'b1}};
	localparam int RGBW = 24;
	localparam int RADW = 12;
	localparam int GAINW = 10;
	localparam logic [RADW-1:0] RADIUS_RST = 12'd300;
	localparam logic [GAINW-1:0] GAIN_RST = 10'd150;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;
	localparam logic REG_RADIUS = 1'b0;
	localparam logic REG_GAIN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_DSUM,
		ST_QGO,
		ST_QWAIT,
		ST_MUL,
		ST_ACC,
		ST_GAIN,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic ld;
		logic shift;
	} cell_ctrl_t;

endpackage

// ===== rtl/metaball_field_shader_unit.sv =====
// ----------------------------------------------------------------------------
// metaball_field_shader_unit
// Ball table in a ring of cells, shared squarer and divider, sums per pixel.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | action, ball_index, coord, colors
// out     | output    | out_valid / out_stall  | grey, red, green, blue levels
// cfg     | input     | apb psel/penable/pready| ball_radius, grey_gain
//
// a load item leaves the block idle; a pixel item stalls the input until
// its result goes to the output register, with a QNW = 32 bit quotient per
// ball from the one-bit-per-cycle divider shared by all balls
// the ring rotates once per pixel and returns every entry to its own cell
// reset clears the ball table to black balls at the origin
// a finished result waits in the output register while the next item is taken
module metaball_field_shader_unit #(
	parameter int BALL_COUNT = 8,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  action,
	input  logic [2:0]            ball_index,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	input  logic [7:0]            color_red,
	input  logic [7:0]            color_green,
	input  logic [7:0]            color_blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            grey_level,
	output logic [7:0]            red_level,
	output logic [7:0]            green_level,
	output logic [7:0]            blue_level
);
	import mfs_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int LB = $clog2(BALL_COUNT);
	localparam int IDXW = (BALL_COUNT > 1) ? $clog2(BALL_COUNT) : 1;
	localparam int SQW = 2 * CB;
	localparam int DW = SQW + 1;
	localparam int QNW = 2 * RADW + 8;
	localparam int SUMW = QW + LB;
	localparam int CSW = QW + 8 + LB;
	localparam int NW = SUMW + GAINW;
	localparam int TB = 8 + LB;
	localparam int KSH = TB + LB;
	localparam int PW = TB + KSH + 1;
	localparam logic [NW-9:0] TLIM = (NW-8)'(BALL_COUNT * 256);
	localparam logic [KSH:0] RECIP = (KSH+1)'(((1 << KSH) + BALL_COUNT - 1) / BALL_COUNT);

	state_t state_q, state_d;
	logic [RADW-1:0] radius_q;
	logic [GAINW-1:0] gain_q;
	logic in_acc, cfg_wr;

	logic [CB-1:0] cx [BALL_COUNT];
	logic [CB-1:0] cy [BALL_COUNT];
	logic [RGBW-1:0] crgb [BALL_COUNT];
	logic shift;

	logic [CB-1:0] px_q, py_q, dx, dy;
	logic [2*RADW-1:0] rsq;
	logic [QNW-1:0] num_q;
	logic [SQW-1:0] sqx_q, sqy_q;
	logic [DW-1:0] d_q;
	logic [RGBW-1:0] col_q;
	logic [QW-1:0] q_q;
	logic [31:0] pr_q, pg_q, pb_q;
	logic [SUMW-1:0] sv_q;
	logic [CSW-1:0] sr_q, sg_q, sb_q;
	logic [NW-1:0] gv_q;
	logic [IDXW-1:0] ball_q;
	logic [1:0] fin_q;
	logic [7:0] lvl_q [4];
	logic [NW-1:0] fin_v;
	logic [NW-9:0] fin_t;
	logic fin_sat;
	logic [PW-1:0] fin_prod;
	logic [7:0] lvl_fin;
	logic [7:0] grey_q, red_q, green_q, blue_q;
	logic out_valid_q;

	logic div_start, div_done;
	logic [QNW-1:0] div_quo;
	logic [QW-1:0] q_sat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_GAIN) ? 32'(gain_q) : 32'(radius_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_RADIUS) begin
				radius_q <= pwdata[RADW-1:0];
			end else begin
				gain_q <= pwdata[GAINW-1:0];
			end
		end
	end

	assign in_acc = in_valid && !in_stall;

	// ring: cell i takes from cell i+1, cell 0 feeds the datapath
	for (genvar i = 0; i < BALL_COUNT; i++) begin : g_cell
		cell_ctrl_t ctrl;
		assign ctrl.ld = in_acc && (action == ACT_LOAD) && (i < 8) && (ball_index == 3'(i));
		assign ctrl.shift = shift;
		mfs_cell #(.CB(CB)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.ld_x   (coord_x),
			.ld_y   (coord_y),
			.ld_rgb ({color_red, color_green, color_blue}),
			.nb_x   (cx[(i + 1) % BALL_COUNT]),
			.nb_y   (cy[(i + 1) % BALL_COUNT]),
			.nb_rgb (crgb[(i + 1) % BALL_COUNT]),
			.x      (cx[i]),
			.y      (cy[i]),
			.rgb    (crgb[i])
		);
	end

	assign dx = (cx[0] >= px_q) ? cx[0] - px_q : px_q - cx[0];
	assign dy = (cy[0] >= py_q) ? cy[0] - py_q : py_q - cy[0];
	assign rsq = radius_q * radius_q;

	mfs_div #(.NW(QNW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// divide by zero gives an all-ones quotient, so it saturates too
	assign q_sat = (|div_quo[QNW-1:QW]) ? Q_MAX : div_quo[QW-1:0];

	always_comb begin
		case (fin_q)
			2'd0: fin_v = gv_q;
			2'd1: fin_v = NW'(sr_q);
			2'd2: fin_v = NW'(sg_q);
			default: fin_v = NW'(sb_q);
		endcase
	end

	// average over the ball count: drop the fraction, then a reciprocal multiply
	// that is exact while the value stays below 256*BALL_COUNT
	assign fin_t = fin_v[NW-1:8];
	assign fin_sat = fin_t >= TLIM;
	assign fin_prod = PW'(fin_t[TB-1:0]) * PW'(RECIP);
	assign lvl_fin = fin_sat ? 8'hFF : fin_prod[KSH+7:KSH];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && action == ACT_PIXEL) state_d = ST_SQ;
			ST_SQ: state_d = ST_DSUM;
			ST_DSUM: state_d = ST_QGO;
			ST_QGO: state_d = ST_QWAIT;
			ST_QWAIT: if (div_done) state_d = ST_MUL;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = (ball_q == IDXW'(BALL_COUNT - 1)) ? ST_GAIN : ST_SQ;
			ST_GAIN: state_d = ST_FIN;
			ST_FIN: if (fin_q == 2'd3) state_d = ST_OUT;
			ST_OUT: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		shift = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_SQ: shift = 1'b1;
			ST_QGO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			ball_q <= '0;
			fin_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				ball_q <= '0;
				fin_q <= '0;
			end else if (state_q == ST_ACC) begin
				ball_q <= ball_q + 1'b1;
			end else if (state_q == ST_FIN) begin
				fin_q <= fin_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_PIXEL) begin
			px_q <= coord_x;
			py_q <= coord_y;
			num_q <= {rsq, 8'h00};
			sv_q <= '0;
			sr_q <= '0;
			sg_q <= '0;
			sb_q <= '0;
		end
		unique case (state_q)
			ST_SQ: begin
				sqx_q <= dx * dx;
				sqy_q <= dy * dy;
				col_q <= crgb[0];
			end
			ST_DSUM: d_q <= DW'(sqx_q) + DW'(sqy_q);
			ST_QWAIT: if (div_done) q_q <= q_sat;
			ST_MUL: begin
				pr_q <= q_q * col_q[23:16];
				pg_q <= q_q * col_q[15:8];
				pb_q <= q_q * col_q[7:0];
			end
			ST_ACC: begin
				sv_q <= sv_q + SUMW'(q_q);
				sr_q <= sr_q + CSW'(pr_q);
				sg_q <= sg_q + CSW'(pg_q);
				sb_q <= sb_q + CSW'(pb_q);
			end
			ST_GAIN: gv_q <= sv_q * gain_q;
			ST_FIN: lvl_q[fin_q] <= lvl_fin;
			ST_OUT: if (!out_valid_q || !out_stall) begin
				grey_q <= lvl_q[0];
				red_q <= lvl_q[1];
				green_q <= lvl_q[2];
				blue_q <= lvl_q[3];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign grey_level = grey_q;
	assign red_level = red_q;
	assign green_level = green_q;
	assign blue_level = blue_q;
endmodule

// ===== rtl/mfs_cell.sv =====
// ----------------------------------------------------------------------------
// mfs_cell
// One ball entry of the ring: loads its own entry or takes its neighbor's.
// ----------------------------------------------------------------------------
module mfs_cell #(
	parameter int CB = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfs_pkg::cell_ctrl_t   ctrl,
	input  logic [CB-1:0]         ld_x,
	input  logic [CB-1:0]         ld_y,
	input  logic [mfs_pkg::RGBW-1:0] ld_rgb,
	input  logic [CB-1:0]         nb_x,
	input  logic [CB-1:0]         nb_y,
	input  logic [mfs_pkg::RGBW-1:0] nb_rgb,
	output logic [CB-1:0]         x,
	output logic [CB-1:0]         y,
	output logic [mfs_pkg::RGBW-1:0] rgb
);
	import mfs_pkg::*;

	logic [CB-1:0] x_q, y_q;
	logic [RGBW-1:0] rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			rgb_q <= '0;
		end else if (ctrl.ld) begin
			x_q <= ld_x;
			y_q <= ld_y;
			rgb_q <= ld_rgb;
		end else if (ctrl.shift) begin
			x_q <= nb_x;
			y_q <= nb_y;
			rgb_q <= nb_rgb;
		end
	end

	assign x = x_q;
	assign y = y_q;
	assign rgb = rgb_q;
endmodule

// ===== rtl/mfs_div.sv =====
// ----------------------------------------------------------------------------
// mfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfs_div #(
	parameter int NW = 37,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q, dvs_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic [DW:0] trial;
	logic ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/mfs_checker.sv =====
// ----------------------------------------------------------------------------
// mfs_checker
// Port-level checks of the metaball field shader, bound to the top level.
// ----------------------------------------------------------------------------
module mfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       in_valid,
	input logic       in_stall,
	input logic       action,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] grey_level,
	input logic [7:0] red_level
);
	import mfs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("out item dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(grey_level) && $stable(red_level))
		else $error("stalled out item changed");

	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_PIXEL |=> in_stall)
		else $error("pixel item did not occupy the block");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_LOAD |=> !in_stall)
		else $error("load item stalled the block");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind metaball_field_shader_unit mfs_checker u_mfs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.action     (action),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.grey_level (grey_level),
	.red_level  (red_level)
);
